>>> rtl/core/swipe_pkg.sv
// Shared types and constants for the swipe gesture detector.
// Event kinds, direction codes, register indexes and reset values.
// No dependencies.
package swipe_pkg;

  // default coordinate width and fixed field widths
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned TIME_BITS      = 32;
  localparam int unsigned DIST_BITS      = 12;
  localparam int unsigned RATIO_BITS     = 8;
  localparam int unsigned ROT_BITS       = 2;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned MODE_BITS      = 2;
  localparam int unsigned DIR_BITS       = 3;
  localparam int unsigned RATIO_FRAC     = 4;

  // register reset values
  localparam logic [DIST_BITS-1:0]  MIN_DIST_RST  = DIST_BITS'(40);
  localparam logic [RATIO_BITS-1:0] RATIO_RST     = RATIO_BITS'(32);
  localparam logic [TIME_BITS-1:0]  MAX_DUR_RST   = TIME_BITS'(500);
  localparam logic [ROT_BITS-1:0]   ROT_RST       = '0;

  // event kind carried in tuser
  typedef enum logic [MODE_BITS-1:0] {
    MODE_TOUCH  = 2'd0,
    MODE_LIFT   = 2'd1,
    MODE_CANCEL = 2'd2
  } mode_e;

  // reported swipe direction
  typedef enum logic [DIR_BITS-1:0] {
    DIR_NONE  = 3'd0,
    DIR_LEFT  = 3'd1,
    DIR_RIGHT = 3'd2,
    DIR_UP    = 3'd3,
    DIR_DOWN  = 3'd4
  } dir_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DIST = 2'd0,
    REG_RATIO    = 2'd1,
    REG_MAX_DUR  = 2'd2,
    REG_ROTATION = 2'd3
  } cfg_idx_e;

  // display rotation in quarter turns
  typedef enum logic [ROT_BITS-1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

endpackage

>>> rtl/core/swipe_gesture_detector.sv
// Swipe gesture detector: touch event stream in, one direction beat per lift out.
// Depends on swipe_pkg.
//
// One event beat is taken every cycle while the input side is not stalled. A beat
// goes into an input register; when it is consumed the gesture state is updated
// and, for a lift, the direction is written to the output register, which offers
// the result. Touch and cancel beats never wait; a lift waits in the input register
// only while the output register still holds a result that has not been taken, and
// then the input side stalls for as long as the output side does. tuser carries the
// event kind (0 touch, 1 lift, 2 cancel, 3 ignored). The user must write
// configuration through the plain write port only while no event is in flight; the
// block itself does not enforce it.
module swipe_gesture_detector #(
  parameter int unsigned COORD_BITS = swipe_pkg::COORD_BITS_DEF,
  localparam int unsigned InDataW   = ((2 * COORD_BITS + swipe_pkg::TIME_BITS + 7) / 8) * 8,
  localparam int unsigned OutDataW  = ((swipe_pkg::DIR_BITS + 7) / 8) * 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [swipe_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [swipe_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // event input
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [InDataW-1:0]                   s_axis_tdata,  // touch_x, touch_y, time_ms
  input  logic [swipe_pkg::MODE_BITS-1:0]      s_axis_tuser,  // mode
  // direction output
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [OutDataW-1:0]                  m_axis_tdata   // direction
);
  import swipe_pkg::*;

  localparam int unsigned DistCmpW = (COORD_BITS > DIST_BITS) ? COORD_BITS : DIST_BITS;
  localparam int unsigned ProdW    = COORD_BITS + RATIO_BITS;

  // configuration registers
  logic [DIST_BITS-1:0]  min_dist_q;
  logic [RATIO_BITS-1:0] ratio_q;
  logic [TIME_BITS-1:0]  max_dur_q;
  rot_e                  rot_q;

  // input register
  logic                  in_vld_q;
  mode_e                 in_mode_q;
  logic [COORD_BITS-1:0] in_x_q;
  logic [COORD_BITS-1:0] in_y_q;
  logic [TIME_BITS-1:0]  in_time_q;

  // gesture state
  logic                  active_q;
  logic                  cancelled_q;
  logic [COORD_BITS-1:0] start_x_q;
  logic [COORD_BITS-1:0] start_y_q;
  logic [TIME_BITS-1:0]  start_time_q;
  logic [COORD_BITS-1:0] last_x_q;
  logic [COORD_BITS-1:0] last_y_q;

  // output register
  logic                  out_vld_q;
  dir_e                  out_dir_q;

  logic                  is_lift;
  logic                  out_free;
  logic                  consume;
  logic                  take_in;

  // travel and judgement
  logic signed [COORD_BITS:0] px;
  logic signed [COORD_BITS:0] py;
  logic signed [COORD_BITS:0] lx;
  logic signed [COORD_BITS:0] ly;
  logic signed [COORD_BITS:0] lx_neg;
  logic signed [COORD_BITS:0] ly_neg;
  logic [COORD_BITS-1:0]      ax;
  logic [COORD_BITS-1:0]      ay;
  logic                       horiz;
  logic [COORD_BITS-1:0]      dom;
  logic [COORD_BITS-1:0]      oth;
  logic                       dist_ok;
  logic [ProdW-1:0]           dom_scaled;
  logic [ProdW-1:0]           oth_scaled;
  logic                       ratio_ok;
  logic [TIME_BITS-1:0]       elapsed;
  logic                       time_ok;
  dir_e                       swipe_dir;
  dir_e                       lift_dir;

  // handshake: non-lift beats always drain, a lift needs a free output register
  assign is_lift       = (in_mode_q == MODE_LIFT);
  assign out_free      = !out_vld_q || m_axis_tready;
  assign consume       = in_vld_q && (!is_lift || out_free);
  assign s_axis_tready = !in_vld_q || consume;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutDataW'(out_dir_q);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= MIN_DIST_RST;
      ratio_q    <= RATIO_RST;
      max_dur_q  <= MAX_DUR_RST;
      rot_q      <= rot_e'(ROT_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_MIN_DIST: min_dist_q <= cfg_data_i[DIST_BITS-1:0];
        REG_RATIO:    ratio_q    <= cfg_data_i[RATIO_BITS-1:0];
        REG_MAX_DUR:  max_dur_q  <= cfg_data_i[TIME_BITS-1:0];
        REG_ROTATION: rot_q      <= rot_e'(cfg_data_i[ROT_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_mode_q <= mode_e'(s_axis_tuser);
      in_x_q    <= s_axis_tdata[COORD_BITS-1:0];
      in_y_q    <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
      in_time_q <= s_axis_tdata[2*COORD_BITS+TIME_BITS-1:2*COORD_BITS];
    end
  end

  // travel, rotated back into display axes
  always_comb begin
    px     = $signed({1'b0, last_x_q}) - $signed({1'b0, start_x_q});
    py     = $signed({1'b0, last_y_q}) - $signed({1'b0, start_y_q});
    lx     = px;
    ly     = py;
    unique case (rot_q)
      ROT_0: begin
        lx = px;
        ly = py;
      end
      ROT_90: begin
        lx = py;
        ly = -px;
      end
      ROT_180: begin
        lx = -px;
        ly = -py;
      end
      ROT_270: begin
        lx = -py;
        ly = px;
      end
      default: begin
        lx = px;
        ly = py;
      end
    endcase
    lx_neg = -lx;
    ly_neg = -ly;
  end

  // magnitudes, dominant axis and thresholds (tie goes horizontal)
  always_comb begin
    ax         = lx[COORD_BITS] ? lx_neg[COORD_BITS-1:0] : lx[COORD_BITS-1:0];
    ay         = ly[COORD_BITS] ? ly_neg[COORD_BITS-1:0] : ly[COORD_BITS-1:0];
    horiz      = (ax >= ay);
    dom        = horiz ? ax : ay;
    oth        = horiz ? ay : ax;
    dist_ok    = (DistCmpW'(dom) >= DistCmpW'(min_dist_q));
    dom_scaled = ProdW'(dom) << RATIO_FRAC;
    oth_scaled = ProdW'(ratio_q) * ProdW'(oth);
    ratio_ok   = (dom_scaled >= oth_scaled);
    elapsed    = in_time_q - start_time_q;
    time_ok    = !cancelled_q && (elapsed <= max_dur_q);
    swipe_dir  = DIR_NONE;
    if (dist_ok && ratio_ok) begin
      if (horiz) begin
        swipe_dir = lx[COORD_BITS] ? DIR_LEFT : DIR_RIGHT;
      end else begin
        swipe_dir = ly[COORD_BITS] ? DIR_UP : DIR_DOWN;
      end
    end
    lift_dir = (active_q && time_ok) ? swipe_dir : DIR_NONE;
  end

  // gesture state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      cancelled_q  <= 1'b0;
      start_x_q    <= '0;
      start_y_q    <= '0;
      start_time_q <= '0;
      last_x_q     <= '0;
      last_y_q     <= '0;
    end else if (consume) begin
      unique case (in_mode_q)
        MODE_TOUCH: begin
          if (!active_q) begin
            active_q     <= 1'b1;
            cancelled_q  <= 1'b0;
            start_x_q    <= in_x_q;
            start_y_q    <= in_y_q;
            start_time_q <= in_time_q;
          end
          last_x_q <= in_x_q;
          last_y_q <= in_y_q;
        end
        MODE_CANCEL: begin
          if (active_q) begin
            cancelled_q <= 1'b1;
          end
        end
        MODE_LIFT: begin
          active_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (consume && is_lift) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (consume && is_lift) begin
      out_dir_q <= lift_dir;
    end
  end

  // a result only appears after a lift was processed
  a_result_from_lift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(consume && is_lift))
    else $error("result without a lift");

  // a lift ends the gesture
  a_lift_ends_gesture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && is_lift) |=> !active_q)
    else $error("gesture still active after lift");

  // a lift with no gesture reports none
  a_idle_lift_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && is_lift && !active_q) |=> (out_vld_q && out_dir_q == DIR_NONE))
    else $error("idle lift reported a swipe");

  // a waiting event is not overwritten
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !consume) |=> (in_vld_q && $stable(in_mode_q) && $stable(in_time_q)))
    else $error("pending event lost");

  // a cancelled gesture never reports a swipe
  a_cancel_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && is_lift && cancelled_q) |=> (out_dir_q == DIR_NONE))
    else $error("cancelled gesture reported a swipe");

endmodule

>>> test/swipe_gesture_detector_test.sv
// Self-checking testbench for the swipe gesture detector: directed events, then
// random gestures under several register settings, with random idling on both sides.
// Depends on swipe_pkg and swipe_gesture_detector.
module swipe_gesture_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  import swipe_pkg::*;

  localparam int unsigned EventW    = ((2 * COORD_BITS_DEF + TIME_BITS + 7) / 8) * 8;
  localparam int unsigned DirW      = ((DIR_BITS + 7) / 8) * 8;
  localparam logic [1:0]  MODE_RSVD = 2'd3;
  localparam int          HOLD_LEN  = 300;
  localparam int          IDLE_MAX  = 2000;
  localparam int          PHASE_LEN = 190;

  // one directed event, with the direction typed in where it is obvious
  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] t;
    logic        typed;
    dir_e        want;
  } probe_t;

  localparam probe_t PROBES [25] = '{
    '{MODE_LIFT,   12'd0,    12'd0,    32'd0,          1'b1, DIR_NONE},
    '{MODE_CANCEL, 12'd0,    12'd0,    32'd0,          1'b0, DIR_NONE},
    '{MODE_RSVD,   12'hfff,  12'hfff,  32'hffffffff,   1'b0, DIR_NONE},
    '{MODE_TOUCH,  12'd0,    12'd0,    32'd100,        1'b0, DIR_NONE},
    '{MODE_TOUCH,  12'hfff,  12'd0,    32'd200,        1'b0, DIR_NONE},
    '{MODE_LIFT,   12'd0,    12'd0,    32'd300,        1'b1, DIR_RIGHT},
    '{MODE_TOUCH,  12'hfff,  12'hfff,  32'hffffff00,   1'b0, DIR_NONE},
    '{MODE_TOUCH,  12'd0,    12'hfff,  32'hffffff80,   1'b0, DIR_NONE},
    '{MODE_LIFT,   12'd0,    12'd0,    32'h00000010,   1'b1, DIR_LEFT},
    '{MODE_TOUCH,  12'd100,  12'hfff,  32'd1000,       1'b0, DIR_NONE},
    '{MODE_TOUCH,  12'd100,  12'd0,    32'd1100,       1'b0, DIR_NONE},
    '{MODE_LIFT,   12'd0,    12'd0,    32'd1500,       1'b1, DIR_UP},
    '{MODE_TOUCH,  12'd100,  12'd0,    32'd2000,       1'b0, DIR_NONE},
    '{MODE_TOUCH,  12'd100,  12'hfff,  32'd2100,       1'b0, DIR_NONE},
    '{MODE_LIFT,   12'd0,    12'd0,    32'd2501,       1'b1, DIR_NONE},
    '{MODE_TOUCH,  12'd0,    12'd0,    32'd3000,       1'b0, DIR_NONE},
    '{MODE_CANCEL, 12'd0,    12'd0,    32'd3001,       1'b0, DIR_NONE},
    '{MODE_TOUCH,  12'hfff,  12'd0,    32'd3002,       1'b0, DIR_NONE},
    '{MODE_LIFT,   12'd0,    12'd0,    32'd3003,       1'b1, DIR_NONE},
    '{MODE_TOUCH,  12'd100,  12'd100,  32'd4000,       1'b0, DIR_NONE},
    '{MODE_TOUCH,  12'd200,  12'd200,  32'd4010,       1'b0, DIR_NONE},
    '{MODE_LIFT,   12'd0,    12'd0,    32'd4020,       1'b0, DIR_NONE},
    '{MODE_TOUCH,  12'd100,  12'd100,  32'd5000,       1'b0, DIR_NONE},
    '{MODE_TOUCH,  12'd100,  12'd140,  32'd5010,       1'b0, DIR_NONE},
    '{MODE_LIFT,   12'd0,    12'd0,    32'd5020,       1'b1, DIR_DOWN}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [EventW-1:0]     s_axis_tdata  = '0;
  logic [MODE_BITS-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DirW-1:0]       m_axis_tdata;

  // predictor copy of registers and gesture state
  logic [11:0] cfg_min_dist = MIN_DIST_RST;
  logic [7:0]  cfg_ratio    = RATIO_RST;
  logic [31:0] cfg_max_dur  = MAX_DUR_RST;
  rot_e        cfg_rot      = rot_e'(ROT_RST);
  bit          g_active     = 1'b0;
  bit          g_cancelled  = 1'b0;
  logic [11:0] g_start_x    = '0;
  logic [11:0] g_start_y    = '0;
  logic [31:0] g_start_t    = '0;
  logic [11:0] g_last_x     = '0;
  logic [11:0] g_last_y     = '0;

  dir_e dir_due [$];
  int   faults      = 0;
  int   events_sent = 0;
  int   idle_cycles = 0;
  bit   steady      = 1'b0;
  bit   burst       = 1'b0;
  bit   hold_req    = 1'b0;

  swipe_gesture_detector i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // idle stretch length: mostly short, a few long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [11:0] clamp_coord(int v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'hfff;
    return v[11:0];
  endfunction

  // dominant axis must reach the distance and at least ratio/16 times the other axis
  function automatic bit axis_wins(int dom, int oth);
    if (dom < int'(cfg_min_dist)) return 1'b0;
    return longint'(dom) * 16 >= longint'(cfg_ratio) * longint'(oth);
  endfunction

  // travel rotated back to display axes, then classified
  function automatic dir_e judge_travel();
    int px, py, lx, ly, ax, ay;
    px = int'(g_last_x) - int'(g_start_x);
    py = int'(g_last_y) - int'(g_start_y);
    case (cfg_rot)
      ROT_0: begin
        lx = px;  ly = py;
      end
      ROT_90: begin
        lx = py;  ly = -px;
      end
      ROT_180: begin
        lx = -px; ly = -py;
      end
      default: begin
        lx = -py; ly = px;
      end
    endcase
    ax = (lx < 0) ? -lx : lx;
    ay = (ly < 0) ? -ly : ly;
    if (ax >= ay) begin
      if (!axis_wins(ax, ay)) return DIR_NONE;
      return (lx < 0) ? DIR_LEFT : DIR_RIGHT;
    end
    if (!axis_wins(ay, ax)) return DIR_NONE;
    return (ly < 0) ? DIR_UP : DIR_DOWN;
  endfunction

  // advance gesture state by one event; has_dir set for a lift
  function automatic void predict_event(input logic [1:0] mode, input logic [11:0] x,
                                        input logic [11:0] y, input logic [31:0] now,
                                        output bit has_dir, output dir_e dir);
    logic [31:0] span;
    has_dir = 1'b0;
    dir     = DIR_NONE;
    if (mode == MODE_TOUCH) begin
      if (!g_active) begin
        g_active    = 1'b1;
        g_cancelled = 1'b0;
        g_start_x   = x;
        g_start_y   = y;
        g_start_t   = now;
      end
      g_last_x = x;
      g_last_y = y;
    end else if (mode == MODE_CANCEL) begin
      if (g_active) g_cancelled = 1'b1;
    end else if (mode == MODE_LIFT) begin
      has_dir = 1'b1;
      if (g_active) begin
        g_active = 1'b0;
        span     = now - g_start_t;
        if (!g_cancelled && span <= cfg_max_dur) dir = judge_travel();
      end
    end
  endfunction

  // offer one event beat and wait for it to be taken; called at a rising edge
  task automatic push_event(input logic [1:0] mode, input logic [11:0] x,
                            input logic [11:0] y, input logic [31:0] t,
                            input bit typed, input dir_e want);
    int   gap;
    bit   has_dir;
    dir_e dir;
    gap = (steady || burst || $urandom_range(0, 99) < 55) ? 0 : pick_idle();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= EventW'({t, y, x});
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_event(mode, x, y, t, has_dir, dir);
    if (has_dir) dir_due.push_back(typed ? want : dir);
    if (mode != MODE_RSVD) events_sent++;
  endtask

  task automatic send(input logic [1:0] mode, input logic [11:0] x, input logic [11:0] y,
                      input logic [31:0] t);
    push_event(mode, x, y, t, 1'b0, DIR_NONE);
  endtask

  task automatic send_noise();
    send(2'($urandom_range(0, 3)), 12'($urandom), 12'($urandom), $urandom);
  endtask

  // one well-formed gesture near the current thresholds
  task automatic send_swipe();
    logic [31:0] t0, span;
    int sx, sy, dom, oth, dx, dy, hops, i, pick;
    t0   = $urandom;
    sx   = $urandom_range(0, 4095);
    sy   = $urandom_range(0, 4095);
    pick = $urandom_range(0, 9);
    if (pick < 2) dom = $urandom_range(0, 4095);
    else dom = int'(cfg_min_dist) + int'($urandom_range(0, 60)) - 30;
    if (dom < 0) dom = 0;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      oth = $urandom_range(0, dom);
    end else if (pick < 8) begin
      // just around the ratio boundary
      oth = (cfg_ratio == 0) ? dom : (dom * 16) / int'(cfg_ratio);
      oth = oth + int'($urandom_range(0, 4)) - 2;
      if (oth < 0) oth = 0;
      if (oth > 4095) oth = 4095;
    end else begin
      oth = dom;
    end
    if ($urandom_range(0, 1)) begin
      dx = dom; dy = oth;
    end else begin
      dx = oth; dy = dom;
    end
    if ($urandom_range(0, 1)) dx = -dx;
    if ($urandom_range(0, 1)) dy = -dy;
    send(MODE_TOUCH, clamp_coord(sx), clamp_coord(sy), t0);
    hops = $urandom_range(0, 3);
    for (i = 0; i < hops; i++) begin
      send(MODE_TOUCH, clamp_coord(sx + dx * (i + 1) / 4 + int'($urandom_range(0, 6)) - 3),
           clamp_coord(sy + dy * (i + 1) / 4 + int'($urandom_range(0, 6)) - 3), t0 + i + 1);
      if ($urandom_range(0, 19) == 0) send_noise();
    end
    send(MODE_TOUCH, clamp_coord(sx + dx), clamp_coord(sy + dy), t0 + hops + 1);
    if ($urandom_range(0, 9) == 0) send(MODE_CANCEL, 12'($urandom), 12'($urandom), $urandom);
    case ($urandom_range(0, 3))
      0:       span = $urandom_range(0, (cfg_max_dur > 2000) ? 2000 : cfg_max_dur);
      1:       span = cfg_max_dur;
      2:       span = cfg_max_dur + 1;
      default: span = $urandom;
    endcase
    send(MODE_LIFT, 12'($urandom), 12'($urandom), t0 + span);
  endtask

  // write all four registers on consecutive edges; called at a rising edge
  task automatic program_regs(input logic [11:0] min_dist, input logic [7:0] ratio,
                              input logic [31:0] dur, input rot_e rot);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_MIN_DIST;
    cfg_data_i <= CFG_DATA_W'(min_dist);
    @(posedge clk_i);
    cfg_idx_i  <= REG_RATIO;
    cfg_data_i <= CFG_DATA_W'(ratio);
    @(posedge clk_i);
    cfg_idx_i  <= REG_MAX_DUR;
    cfg_data_i <= dur;
    @(posedge clk_i);
    cfg_idx_i  <= REG_ROTATION;
    cfg_data_i <= CFG_DATA_W'(rot);
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    cfg_min_dist = min_dist;
    cfg_ratio    = ratio;
    cfg_max_dur  = dur;
    cfg_rot      = rot;
  endtask

  // stop offering and wait until every direction has come out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (dir_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // receiver: random stalls, a long hold-off on request, none when steady
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
        m_axis_tready <= 1'b0;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 65) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall_left = pick_idle() - 1;
        m_axis_tready <= 1'b0;
      end
    end
  end

  // direction beat check against the oldest expectation
  always @(posedge clk_i) begin
    dir_e want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (dir_due.size() == 0) begin
        faults++;
        $display("%0t: unexpected direction beat, expected none, got %0d", $time,
                 m_axis_tdata[DIR_BITS-1:0]);
      end else begin
        want = dir_due.pop_front();
        if (m_axis_tdata[DIR_BITS-1:0] !== want) begin
          faults++;
          $display("%0t: direction mismatch, expected %0d (%s), got %0d", $time, want,
                   want.name(), m_axis_tdata[DIR_BITS-1:0]);
        end
      end
    end
  end

  // watchdog on cycles with no beat taken on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_MAX);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    int p, i, target;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed events at reset register values
    for (i = 0; i < 25; i++)
      push_event(PROBES[i].mode, PROBES[i].x, PROBES[i].y, PROBES[i].t, PROBES[i].typed,
                 PROBES[i].want);
    settle();

    // random gestures under a series of register settings
    for (p = 0; p < 8; p++) begin
      case (p)
        0: program_regs(MIN_DIST_RST, RATIO_RST, MAX_DUR_RST, ROT_0);
        1: program_regs(12'd0, 8'd0, 32'hffffffff, ROT_90);
        2: program_regs(12'hfff, 8'hff, 32'd0, ROT_180);
        3: program_regs(12'd16, 8'd16, 32'd1000, ROT_270);
        default: program_regs(12'($urandom_range(0, 200)), 8'($urandom),
                              $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000),
                              rot_e'($urandom_range(0, 3)));
      endcase
      steady = (p == 0);
      if (p == 1) begin
        // receiver holds off while lifts keep coming, so the input side backs up
        hold_req = 1'b1;
        burst    = 1'b1;
        repeat (12) send_swipe();
        burst    = 1'b0;
      end
      target = events_sent + PHASE_LEN;
      while (events_sent < target) begin
        if ($urandom_range(0, 99) < 15) send_noise();
        else send_swipe();
      end
      settle();
    end

    steady = 1'b0;
    settle();
    if (faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/swipe_pkg.sv
rtl/core/swipe_gesture_detector.sv
test/swipe_gesture_detector_test.sv
